@@ rtl/core/ottf_pkg.sv @@
// ----------------------------------------------------------------------------
// ottf_pkg
// Shared types, codes and helpers of the outline to toolpath flattener.
// ----------------------------------------------------------------------------
package ottf_pkg;

  localparam int XY_W      = 32;
  localparam int MODE_W    = 3;
  localparam int SAMPLE_W  = 6;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int CMAX_W    = 48;
  localparam int QDEPTH    = 2;
  localparam int DIV_STEPS = 8;

  localparam logic [SAMPLE_W-1:0]   SAMPLES_RST = 6'd8;
  localparam logic signed [XY_W-1:0] ONE_Q      = 32'sd65536;

  typedef enum logic [MODE_W-1:0] {
    CMD_MOVE  = 3'd0,
    CMD_LINE  = 3'd1,
    CMD_QUAD  = 3'd2,
    CMD_CUBIC = 3'd3,
    CMD_CLOSE = 3'd4
  } cmd_kind_e;

  typedef enum logic [1:0] {
    REG_SAMPLES    = 2'd0,
    REG_OFFSET_X   = 2'd1,
    REG_OFFSET_Y   = 2'd2,
    REG_CUT_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MOVE,
    BK_PLUNGE,
    BK_LERP,
    BK_WAIT,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic reload_x;
    logic reload_y;
  } reload_t;

  // clamp a 33-bit sum into a signed range of cw bits
  function automatic logic signed [CMAX_W-1:0] sat_coord(input logic signed [XY_W:0] v,
                                                         input int cw);
    logic signed [CMAX_W-1:0] ve;
    logic signed [CMAX_W-1:0] hi;
    logic signed [CMAX_W-1:0] lo;
    ve = CMAX_W'(v);
    hi = signed'((CMAX_W'(1) << (cw - 1)) - CMAX_W'(1));
    lo = ~hi;
    if (ve > hi) begin
      return hi;
    end else if (ve < lo) begin
      return lo;
    end
    return ve;
  endfunction

endpackage

@@ rtl/core/ottf_if.sv @@
// ----------------------------------------------------------------------------
// ottf channel interfaces
// Valid/ready channels for outline commands and emitted tool points.
// ----------------------------------------------------------------------------
interface ottf_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [ottf_pkg::MODE_W-1:0]         mode;
  logic signed [ottf_pkg::XY_W-1:0]    first_x;
  logic signed [ottf_pkg::XY_W-1:0]    first_y;
  logic signed [ottf_pkg::XY_W-1:0]    second_x;
  logic signed [ottf_pkg::XY_W-1:0]    second_y;
  logic signed [ottf_pkg::XY_W-1:0]    third_x;
  logic signed [ottf_pkg::XY_W-1:0]    third_y;

  modport source (output valid, mode, first_x, first_y, second_x, second_y, third_x, third_y,
                  input ready);
  modport sink (input valid, mode, first_x, first_y, second_x, second_y, third_x, third_y,
                output ready);
endinterface

interface ottf_pt_if;
  logic                             valid;
  logic                             ready;
  logic signed [ottf_pkg::XY_W-1:0] point_x;
  logic signed [ottf_pkg::XY_W-1:0] point_y;
  logic signed [ottf_pkg::XY_W-1:0] point_z;
  logic                             engaged;
  logic                             last;

  modport source (output valid, point_x, point_y, point_z, engaged, last, input ready);
  modport sink (input valid, point_x, point_y, point_z, engaged, last, output ready);
endinterface

@@ rtl/core/ottf_fifo.sv @@
// ----------------------------------------------------------------------------
// ottf_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module ottf_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);
  import ottf_pkg::*;

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  logic [W-1:0]  mem_q [QDEPTH];
  logic [AW-1:0] wr_q;
  logic [AW-1:0] rd_q;
  logic [NW-1:0] cnt_q;
  logic          push;
  logic          pop;

  assign push_ready_o = (cnt_q != NW'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == AW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == AW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/ottf_front.sv @@
// ----------------------------------------------------------------------------
// ottf_front
// Accepts commands, applies offsets with saturation and decides which
// points each command causes (rapid, plunge, curve), queuing it if any.
// ----------------------------------------------------------------------------
module ottf_front #(
  parameter int CW = 32,
  localparam int RW = ottf_pkg::MODE_W + 2 + 6 * CW
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ottf_cmd_if.sink                           cmd_i,
  input  logic signed [ottf_pkg::XY_W-1:0]   off_x_i,
  input  logic signed [ottf_pkg::XY_W-1:0]   off_y_i,
  output logic                               q_valid_o,
  input  logic                               q_ready_i,
  output logic [RW-1:0]                      q_data_o
);
  import ottf_pkg::*;

  typedef struct packed {
    cmd_kind_e             kind;
    logic                  plunge;
    logic                  curve;
    logic signed [CW-1:0]  x1;
    logic signed [CW-1:0]  y1;
    logic signed [CW-1:0]  x2;
    logic signed [CW-1:0]  y2;
    logic signed [CW-1:0]  x3;
    logic signed [CW-1:0]  y3;
  } cmd_rec_t;

  cmd_rec_t rec;
  cmd_rec_t rec_q;
  logic     v_q;
  logic     open_q;
  logic     pend_q;
  logic     known;
  logic     is_move;
  logic     keep;
  logic     in_acc;

  function automatic logic signed [CW-1:0] add_off(input logic signed [XY_W-1:0] v,
                                                   input logic signed [XY_W-1:0] o);
    logic signed [XY_W:0] s;
    s = {v[XY_W-1], v} + {o[XY_W-1], o};
    return CW'(sat_coord(s, CW));
  endfunction

  assign cmd_i.ready = !v_q || q_ready_i;
  assign in_acc      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    known       = (cmd_i.mode <= CMD_CLOSE);
    is_move     = (cmd_i.mode == CMD_MOVE);
    rec.kind    = cmd_kind_e'(cmd_i.mode);
    rec.plunge  = !is_move && pend_q;
    rec.curve   = !is_move && ((cmd_i.mode != CMD_CLOSE) || open_q);
    rec.x1      = add_off(cmd_i.first_x, off_x_i);
    rec.y1      = add_off(cmd_i.first_y, off_y_i);
    rec.x2      = add_off(cmd_i.second_x, off_x_i);
    rec.y2      = add_off(cmd_i.second_y, off_y_i);
    rec.x3      = add_off(cmd_i.third_x, off_x_i);
    rec.y3      = add_off(cmd_i.third_y, off_y_i);
    // close with nothing open and no plunge armed causes no point
    keep        = known && (is_move || rec.plunge || rec.curve);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      open_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      if (in_acc) begin
        v_q <= keep;
      end else if (q_ready_i) begin
        v_q <= 1'b0;
      end
      if (in_acc && known) begin
        if (is_move) begin
          open_q <= 1'b1;
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rec_q <= rec;
    end
  end

  assign q_valid_o = v_q;
  assign q_data_o  = rec_q;

endmodule

@@ rtl/core/ottf_lerp.sv @@
// ----------------------------------------------------------------------------
// ottf_lerp
// One interpolation lane: a + floor((2*(b-a)*i + n) / (2*n)), with the
// division done a byte of quotient per cycle.
// ----------------------------------------------------------------------------
module ottf_lerp #(
  parameter int CW = 32,
  parameter int NW = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [CW-1:0] a_i,
  input  logic signed [CW-1:0] b_i,
  input  logic [NW-1:0]        step_i,
  input  logic [NW-1:0]        n_i,
  output logic                 done_o,
  output logic signed [CW-1:0] res_o
);
  import ottf_pkg::*;

  localparam int MW    = CW + NW + 3;
  localparam int CYC   = (MW - 1 + DIV_STEPS - 1) / DIV_STEPS;
  localparam int PW    = CYC * DIV_STEPS;
  localparam int CNT_W = (CYC > 1) ? $clog2(CYC) : 1;
  localparam int DW    = NW + 1;

  logic signed [CW:0]      diff;
  logic signed [CW+NW+1:0] prod;
  logic signed [MW-1:0]    num;
  logic                    neg;
  logic [MW-2:0]           mag;

  logic                    busy_q;
  logic                    done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [CW-1:0]    a_q;
  logic                    neg_q;
  logic [PW-1:0]           nm_q;
  logic [PW-1:0]           qt_q;
  logic [DW-1:0]           rem_q;
  logic [DW-1:0]           den_q;

  logic [PW-1:0]           nm_n;
  logic [PW-1:0]           qt_n;
  logic [DW-1:0]           r_n;
  logic [DW:0]             r2;

  logic signed [MW-1:0]    q_s;
  logic signed [MW-1:0]    sum;

  always_comb begin
    diff = {b_i[CW-1], b_i} - {a_i[CW-1], a_i};
    prod = diff * $signed({1'b0, step_i});
    num  = {prod, 1'b0} + MW'(n_i);
    neg  = num[MW-1];
    // floor of a negative numerator through the complement
    mag  = neg ? ~num[MW-2:0] : num[MW-2:0];
  end

  always_comb begin
    r_n  = rem_q;
    nm_n = nm_q;
    qt_n = qt_q;
    r2   = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r2   = {r_n, nm_n[PW-1]};
      nm_n = nm_n << 1;
      if (r2 >= {1'b0, den_q}) begin
        r2   = r2 - {1'b0, den_q};
        qt_n = {qt_n[PW-2:0], 1'b1};
      end else begin
        qt_n = {qt_n[PW-2:0], 1'b0};
      end
      r_n = r2[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CYC - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      neg_q <= neg;
      nm_q  <= PW'(mag);
      qt_q  <= '0;
      rem_q <= '0;
      den_q <= {n_i, 1'b0};
    end else if (busy_q) begin
      nm_q  <= nm_n;
      qt_q  <= qt_n;
      rem_q <= r_n;
    end
  end

  always_comb begin
    q_s = {1'b0, qt_q[MW-2:0]};
    if (neg_q) begin
      q_s = ~q_s;
    end
    sum = {{(MW - CW){a_q[CW-1]}}, a_q} + q_s;
  end

  assign res_o  = sum[CW-1:0];
  assign done_o = done_q;

endmodule

@@ rtl/core/ottf_back.sv @@
// ----------------------------------------------------------------------------
// ottf_back
// Carries out queued commands: rapid and plunge points, and de Casteljau
// levels on six interpolation lanes, into a registered point output.
// ----------------------------------------------------------------------------
module ottf_back #(
  parameter int CW = 32,
  parameter int NW = 6,
  localparam int RW = ottf_pkg::MODE_W + 2 + 6 * CW
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  output logic                             q_ready_o,
  input  logic [RW-1:0]                    q_data_i,
  input  logic [NW-1:0]                    n_i,
  input  logic signed [ottf_pkg::XY_W-1:0] cut_i,
  input  ottf_pkg::reload_t                reload_i,
  input  logic signed [CW-1:0]             off_x_i,
  input  logic signed [CW-1:0]             off_y_i,
  ottf_pt_if.source                        pt_o
);
  import ottf_pkg::*;

  typedef struct packed {
    cmd_kind_e             kind;
    logic                  plunge;
    logic                  curve;
    logic signed [CW-1:0]  x1;
    logic signed [CW-1:0]  y1;
    logic signed [CW-1:0]  x2;
    logic signed [CW-1:0]  y2;
    logic signed [CW-1:0]  x3;
    logic signed [CW-1:0]  y3;
  } cmd_rec_t;

  localparam int EW = ((CW > XY_W) ? CW : XY_W) + 1;

  function automatic logic signed [XY_W-1:0] sat_xy(input logic signed [CW-1:0] v);
    logic signed [EW-1:0] ve;
    logic signed [EW-1:0] hi;
    logic signed [EW-1:0] lo;
    ve = EW'(v);
    hi = EW'(32'sh7fff_ffff);
    lo = EW'(signed'(32'h8000_0000));
    if (ve > hi) begin
      return hi[XY_W-1:0];
    end else if (ve < lo) begin
      return lo[XY_W-1:0];
    end
    return ve[XY_W-1:0];
  endfunction

  back_state_e          state_q, state_d;
  cmd_rec_t             q_rec;
  cmd_rec_t             cmd_q;
  logic [NW-1:0]        i_q;
  logic [1:0]           lvl_q;
  logic [1:0]           last_lvl;
  logic signed [CW-1:0] cur_x_q, cur_y_q, start_x_q, start_y_q;
  logic signed [CW-1:0] r_q [2][3];
  logic signed [CW-1:0] pc [2][5];
  logic signed [CW-1:0] op_a [2][3];
  logic signed [CW-1:0] op_b [2][3];
  logic signed [CW-1:0] lane_res [2][3];
  logic [2:0]           lane_dn [2];
  logic                 lane_done;
  logic                 lane_start;
  logic                 pop;
  logic                 load;
  logic                 can_load;

  logic                   ov_q;
  logic signed [XY_W-1:0] px_q, py_q, pz_q;
  logic                   eng_q, last_q;
  logic signed [XY_W-1:0] o_x, o_y, o_z;
  logic                   o_eng, o_last;

  logic signed [XY_W:0]   cut_m;
  logic signed [XY_W-1:0] safe_z;

  assign q_rec     = cmd_rec_t'(q_data_i);
  assign can_load  = !ov_q || pt_o.ready;
  assign q_ready_o = (state_q == BK_IDLE);
  assign lane_done = &{lane_dn[0], lane_dn[1]};

  always_comb begin
    cut_m  = {cut_i[XY_W-1], cut_i} - {ONE_Q[XY_W-1], ONE_Q};
    safe_z = cut_m[XY_W-1:0];
    if (cut_m[XY_W] != cut_m[XY_W-1]) begin
      safe_z = signed'(32'h8000_0000);
    end
    if (safe_z > -ONE_Q) begin
      safe_z = -ONE_Q;
    end
  end

  always_comb begin
    unique case (cmd_q.kind)
      CMD_CUBIC: last_lvl = 2'd3;
      CMD_QUAD:  last_lvl = 2'd2;
      default:   last_lvl = 2'd1;
    endcase
  end

  // control points per axis: current, p1, p2, p3, subpath start
  always_comb begin
    pc[0][0] = cur_x_q;  pc[0][1] = cmd_q.x1; pc[0][2] = cmd_q.x2;
    pc[0][3] = cmd_q.x3; pc[0][4] = start_x_q;
    pc[1][0] = cur_y_q;  pc[1][1] = cmd_q.y1; pc[1][2] = cmd_q.y2;
    pc[1][3] = cmd_q.y3; pc[1][4] = start_y_q;
    for (int ax = 0; ax < 2; ax++) begin
      for (int ln = 0; ln < 3; ln++) begin
        op_a[ax][ln] = r_q[ax][ln];
        op_b[ax][ln] = r_q[ax][(ln < 2) ? ln + 1 : ln];
      end
      if (lvl_q == 2'd1) begin
        op_a[ax][0] = pc[ax][0]; op_b[ax][0] = pc[ax][1];
        op_a[ax][1] = pc[ax][1]; op_b[ax][1] = pc[ax][2];
        op_a[ax][2] = pc[ax][2]; op_b[ax][2] = pc[ax][3];
        unique case (cmd_q.kind)
          CMD_LINE: begin
            op_a[ax][0] = pc[ax][1];
            op_b[ax][0] = pc[ax][3];
          end
          CMD_QUAD: begin
            op_a[ax][0] = pc[ax][1]; op_b[ax][0] = pc[ax][2];
            op_a[ax][1] = pc[ax][2]; op_b[ax][1] = pc[ax][3];
          end
          CMD_CLOSE: begin
            op_b[ax][0] = pc[ax][4];
          end
          default: begin
          end
        endcase
      end
    end
  end

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    for (genvar ln = 0; ln < 3; ln++) begin : g_lane
      ottf_lerp #(
        .CW (CW),
        .NW (NW)
      ) u_lerp (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .start_i (lane_start),
        .a_i     (op_a[ax][ln]),
        .b_i     (op_b[ax][ln]),
        .step_i  (i_q),
        .n_i     (n_i),
        .done_o  (lane_dn[ax][ln]),
        .res_o   (lane_res[ax][ln])
      );
    end
  end

  always_comb begin
    state_d    = state_q;
    pop        = 1'b0;
    lane_start = 1'b0;
    load       = 1'b0;
    o_x        = sat_xy(cur_x_q);
    o_y        = sat_xy(cur_y_q);
    o_z        = cut_i;
    o_eng      = 1'b1;
    o_last     = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        pop = q_valid_i;
        if (q_valid_i) begin
          if (q_rec.kind == CMD_MOVE) begin
            state_d = BK_MOVE;
          end else if (q_rec.plunge) begin
            state_d = BK_PLUNGE;
          end else begin
            state_d = BK_LERP;
          end
        end
      end
      BK_MOVE: begin
        o_x    = sat_xy(cmd_q.x1);
        o_y    = sat_xy(cmd_q.y1);
        o_z    = safe_z;
        o_eng  = 1'b0;
        o_last = 1'b1;
        load   = can_load;
        if (can_load) begin
          state_d = BK_IDLE;
        end
      end
      BK_PLUNGE: begin
        o_last = !cmd_q.curve;
        load   = can_load;
        if (can_load) begin
          state_d = cmd_q.curve ? BK_LERP : BK_IDLE;
        end
      end
      BK_LERP: begin
        lane_start = 1'b1;
        state_d    = BK_WAIT;
      end
      BK_WAIT: begin
        if (lane_done) begin
          state_d = (lvl_q == last_lvl) ? BK_EMIT : BK_LERP;
        end
      end
      BK_EMIT: begin
        o_x    = sat_xy(r_q[0][0]);
        o_y    = sat_xy(r_q[1][0]);
        o_last = (i_q == n_i);
        load   = can_load;
        if (can_load) begin
          state_d = o_last ? BK_IDLE : BK_LERP;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      ov_q      <= 1'b0;
      i_q       <= '0;
      lvl_q     <= 2'd1;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      start_x_q <= '0;
      start_y_q <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (pt_o.ready) begin
        ov_q <= 1'b0;
      end
      if (pop) begin
        i_q   <= NW'(1);
        lvl_q <= 2'd1;
      end
      if (state_q == BK_WAIT && lane_done && lvl_q != last_lvl) begin
        lvl_q <= lvl_q + 1'b1;
      end
      if (reload_i.reload_x) begin
        cur_x_q   <= off_x_i;
        start_x_q <= off_x_i;
      end
      if (reload_i.reload_y) begin
        cur_y_q   <= off_y_i;
        start_y_q <= off_y_i;
      end
      if (state_q == BK_MOVE && can_load) begin
        cur_x_q   <= cmd_q.x1;
        cur_y_q   <= cmd_q.y1;
        start_x_q <= cmd_q.x1;
        start_y_q <= cmd_q.y1;
      end
      // current stays the command's start point until its final sample
      if (state_q == BK_EMIT && can_load) begin
        if (o_last) begin
          cur_x_q <= CW'(o_x);
          cur_y_q <= CW'(o_y);
        end else begin
          i_q   <= i_q + 1'b1;
          lvl_q <= 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= q_rec;
    end
    if (state_q == BK_WAIT && lane_done) begin
      for (int ax = 0; ax < 2; ax++) begin
        for (int ln = 0; ln < 3; ln++) begin
          r_q[ax][ln] <= lane_res[ax][ln];
        end
      end
    end
    if (load) begin
      px_q   <= o_x;
      py_q   <= o_y;
      pz_q   <= o_z;
      eng_q  <= o_eng;
      last_q <= o_last;
    end
  end

  assign pt_o.valid   = ov_q;
  assign pt_o.point_x = px_q;
  assign pt_o.point_y = py_q;
  assign pt_o.point_z = pz_q;
  assign pt_o.engaged = eng_q;
  assign pt_o.last    = last_q;

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done |-> state_q == BK_WAIT)
    else $error("lane finished outside the wait state");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_EMIT |-> (i_q != '0) && (i_q <= n_i))
    else $error("sample step out of range");

  a_rapid_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !eng_q |-> last_q)
    else $error("rapid point not marked last");

  a_pop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> state_q != BK_IDLE)
    else $error("command popped but not started");
`endif

endmodule

@@ rtl/core/outline_to_toolpath_flattener.sv @@
// ----------------------------------------------------------------------------
// outline_to_toolpath_flattener
// Turns outline commands into tool points at safe or cut height.
// ----------------------------------------------------------------------------
// Usage: outline commands come in on cmd_i (valid/ready), tool points leave
// on pt_o (valid/ready), one point per handshake, last set on the final point
// of each command; pready is always high. The user must write registers
// over the APB port only while the block is idle; it is not enforced.
// A move gives one rapid point. A drawing command gives an optional plunge
// point and then N points. Each point runs its de Casteljau levels on six
// interpolation lanes, one level at a time, the lane divider producing eight
// quotient bits per cycle. A command is popped in the idle state before its
// points, and each command passes the front register and the queue before
// it reaches the back end.
// The front stage and a two-entry queue keep taking commands while the
// point output stalls; a stalled point holds in its output register and
// the back end waits. Reset loads the register defaults, empties the queue
// and sets the current and subpath start points to zero.
// ----------------------------------------------------------------------------
module outline_to_toolpath_flattener #(
  parameter int MAX_SAMPLES = 32,
  parameter int COORD_BITS  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ottf_cmd_if.sink                        cmd_i,
  ottf_pt_if.source                       pt_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ottf_pkg::PADDR_W-1:0]    paddr,
  input  logic [ottf_pkg::PDATA_W-1:0]    pwdata,
  output logic [ottf_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import ottf_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int NW = $clog2(MAX_SAMPLES + 1);
  localparam int RW = MODE_W + 2 + 6 * CW;

  logic [SAMPLE_W-1:0]    samples_q;
  logic signed [XY_W-1:0] off_x_q, off_y_q, cut_q;
  logic                   wr;
  cfg_reg_e               idx;
  logic [NW-1:0]          n;
  reload_t                reload;
  logic signed [CW-1:0]   new_off;

  logic                   fq_valid, fq_ready;
  logic [RW-1:0]          fq_data;
  logic                   bq_valid, bq_ready;
  logic [RW-1:0]          bq_data;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign idx     = cfg_reg_e'(paddr[3:2]);
  assign new_off = CW'(sat_coord({pwdata[XY_W-1], pwdata}, CW));

  assign reload.reload_x = wr && (idx == REG_OFFSET_X);
  assign reload.reload_y = wr && (idx == REG_OFFSET_Y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= SAMPLES_RST;
      off_x_q   <= '0;
      off_y_q   <= '0;
      cut_q     <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_SAMPLES:    samples_q <= pwdata[SAMPLE_W-1:0];
        REG_OFFSET_X:   off_x_q   <= pwdata;
        REG_OFFSET_Y:   off_y_q   <= pwdata;
        REG_CUT_HEIGHT: cut_q     <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SAMPLES:    prdata = PDATA_W'(samples_q);
      REG_OFFSET_X:   prdata = off_x_q;
      REG_OFFSET_Y:   prdata = off_y_q;
      REG_CUT_HEIGHT: prdata = cut_q;
      default:        prdata = '0;
    endcase
  end

  // zero counts as one, large counts clamp to the lane limit
  always_comb begin
    if (samples_q == '0) begin
      n = NW'(1);
    end else if (samples_q > SAMPLE_W'(MAX_SAMPLES)) begin
      n = NW'(MAX_SAMPLES);
    end else begin
      n = NW'(samples_q);
    end
  end

  ottf_front #(
    .CW (CW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_i),
    .off_x_i   (off_x_q),
    .off_y_i   (off_y_q),
    .q_valid_o (fq_valid),
    .q_ready_i (fq_ready),
    .q_data_o  (fq_data)
  );

  ottf_fifo #(
    .W (RW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_data_o   (bq_data)
  );

  ottf_back #(
    .CW (CW),
    .NW (NW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (bq_valid),
    .q_ready_o (bq_ready),
    .q_data_i  (bq_data),
    .n_i       (n),
    .cut_i     (cut_q),
    .reload_i  (reload),
    .off_x_i   (new_off),
    .off_y_i   (new_off),
    .pt_o      (pt_o)
  );

endmodule
